>>> rtl/osalu_pkg.sv
// ----------------------------------------------------------------------------
// osalu_pkg
// shared constants, operation codes and pipeline stage types of the
// saturating integer unit
// ----------------------------------------------------------------------------
package osalu_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int DATA_W    = 64;
  localparam int HALF_W    = DATA_W / 2;
  localparam int FUNC_W    = 3;
  localparam int CFG_W     = 7;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 3;

  // register index as decoded from paddr[2]
  localparam logic REG_WIDTH = 1'b0;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_SADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_UADD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SSUB = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_USUB = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SMUL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_UMUL = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] smin;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } op_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic              sa;
    logic              sb;
    logic              neg;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] smin;
  } s1_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] smin;
    logic              neg;
    logic [DATA_W-1:0] pp_ll;
    logic [DATA_W-1:0] pp_lh;
    logic [DATA_W-1:0] pp_hl;
    logic [DATA_W-1:0] pp_hh;
    logic [DATA_W-1:0] as_wrap;
    logic              as_ov;
    logic [DATA_W-1:0] as_sat;
  } s2_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] smin;
    logic              neg;
    logic [DATA_W-1:0] prod_lo;
    logic              prod_hi_nz;
    logic [DATA_W-1:0] as_wrap;
    logic              as_ov;
    logic [DATA_W-1:0] as_sat;
  } s3_t;

  typedef struct packed {
    logic [DATA_W-1:0] wrap;
    logic              ov;
    logic [DATA_W-1:0] sat;
  } res_t;

endpackage

>>> rtl/osalu_cfg.sv
// ----------------------------------------------------------------------------
// osalu_cfg
// apb width register and decode of the width into mask and sign bit
// ----------------------------------------------------------------------------
module osalu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [osalu_pkg::ADDR_W-1:0]  paddr,
  input  logic [osalu_pkg::APB_W-1:0]   pwdata,
  output logic [osalu_pkg::APB_W-1:0]   prdata,
  output logic                          pready,
  output osalu_pkg::cfg_t               cfg
);

  logic [osalu_pkg::CFG_W-1:0] width_r;
  logic [osalu_pkg::CFG_W-1:0] width_nxt;
  logic [osalu_pkg::CFG_W-1:0] w_eff;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == osalu_pkg::REG_WIDTH);

  always_comb begin
    width_nxt = width_r;
    if (wr_en) begin
      width_nxt = pwdata[osalu_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= osalu_pkg::CFG_W'(osalu_pkg::MAX_WIDTH);
    end else begin
      width_r <= width_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == osalu_pkg::REG_WIDTH) begin
      prdata = {{(osalu_pkg::APB_W - osalu_pkg::CFG_W){1'b0}}, width_r};
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = osalu_pkg::CFG_W'(1);
    end else if (width_r > osalu_pkg::CFG_W'(osalu_pkg::MAX_WIDTH)) begin
      w_eff = osalu_pkg::CFG_W'(osalu_pkg::MAX_WIDTH);
    end
  end

  always_comb begin
    if (w_eff >= osalu_pkg::CFG_W'(osalu_pkg::DATA_W)) begin
      cfg.mask = '1;
    end else begin
      cfg.mask = (osalu_pkg::DATA_W'(1) << w_eff) - osalu_pkg::DATA_W'(1);
    end
    cfg.smin = osalu_pkg::DATA_W'(1) << (w_eff - osalu_pkg::CFG_W'(1));
  end

endmodule

>>> rtl/osalu_operand.sv
// ----------------------------------------------------------------------------
// osalu_operand
// operand stage: masking to the width, sign bits and multiply magnitudes
// ----------------------------------------------------------------------------
module osalu_operand (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_v,
  input  osalu_pkg::op_t   op,
  input  osalu_pkg::cfg_t  cfg,
  output logic             s1_v,
  output osalu_pkg::s1_t   s1
);

  logic                s1_v_r;
  osalu_pkg::s1_t      s1_r;
  osalu_pkg::s1_t      s1_nxt;
  logic                is_smul;

  always_comb begin
    s1_nxt.func  = op.func;
    s1_nxt.mask  = cfg.mask;
    s1_nxt.smin  = cfg.smin;
    s1_nxt.a     = op.lhs & cfg.mask;
    s1_nxt.b     = op.rhs & cfg.mask;
    s1_nxt.sa    = |(s1_nxt.a & cfg.smin);
    s1_nxt.sb    = |(s1_nxt.b & cfg.smin);
    is_smul      = (op.func == osalu_pkg::FUNC_SMUL);
    // signed multiply works on magnitudes, sign is put back at the end
    s1_nxt.mul_a = (is_smul && s1_nxt.sa) ?
                   ((~s1_nxt.a + osalu_pkg::DATA_W'(1)) & cfg.mask) : s1_nxt.a;
    s1_nxt.mul_b = (is_smul && s1_nxt.sb) ?
                   ((~s1_nxt.b + osalu_pkg::DATA_W'(1)) & cfg.mask) : s1_nxt.b;
    s1_nxt.neg   = is_smul && (s1_nxt.sa != s1_nxt.sb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= op_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_v = s1_v_r;
  assign s1   = s1_r;

endmodule

>>> rtl/osalu_core.sv
// ----------------------------------------------------------------------------
// osalu_core
// add and subtract with overflow and clamp, and the four partial products
// ----------------------------------------------------------------------------
module osalu_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_v,
  input  osalu_pkg::s1_t   s1,
  output logic             s2_v,
  output osalu_pkg::s2_t   s2
);

  logic                          s2_v_r;
  osalu_pkg::s2_t                s2_r;
  osalu_pkg::s2_t                s2_nxt;
  logic [osalu_pkg::DATA_W-1:0]  smax;
  logic [osalu_pkg::DATA_W-1:0]  sum;
  logic [osalu_pkg::DATA_W-1:0]  diff;
  logic                          sum_s;
  logic                          diff_s;
  logic [osalu_pkg::HALF_W-1:0]  a_lo, a_hi, b_lo, b_hi;

  assign smax   = s1.mask >> 1;
  assign sum    = (s1.a + s1.b) & s1.mask;
  assign diff   = (s1.a - s1.b) & s1.mask;
  assign sum_s  = |(sum & s1.smin);
  assign diff_s = |(diff & s1.smin);

  assign a_lo = s1.mul_a[osalu_pkg::HALF_W-1:0];
  assign a_hi = s1.mul_a[osalu_pkg::DATA_W-1:osalu_pkg::HALF_W];
  assign b_lo = s1.mul_b[osalu_pkg::HALF_W-1:0];
  assign b_hi = s1.mul_b[osalu_pkg::DATA_W-1:osalu_pkg::HALF_W];

  always_comb begin
    s2_nxt.func    = s1.func;
    s2_nxt.mask    = s1.mask;
    s2_nxt.smin    = s1.smin;
    s2_nxt.neg     = s1.neg;
    s2_nxt.pp_ll   = osalu_pkg::DATA_W'(a_lo) * osalu_pkg::DATA_W'(b_lo);
    s2_nxt.pp_lh   = osalu_pkg::DATA_W'(a_lo) * osalu_pkg::DATA_W'(b_hi);
    s2_nxt.pp_hl   = osalu_pkg::DATA_W'(a_hi) * osalu_pkg::DATA_W'(b_lo);
    s2_nxt.pp_hh   = osalu_pkg::DATA_W'(a_hi) * osalu_pkg::DATA_W'(b_hi);
    s2_nxt.as_wrap = '0;
    s2_nxt.as_ov   = 1'b0;
    s2_nxt.as_sat  = '0;
    case (s1.func)
      osalu_pkg::FUNC_SADD: begin
        s2_nxt.as_wrap = sum;
        s2_nxt.as_ov   = (s1.sa == s1.sb) && (sum_s != s1.sa);
        s2_nxt.as_sat  = s2_nxt.as_ov ? (s1.sa ? s1.smin : smax) : sum;
      end
      osalu_pkg::FUNC_UADD: begin
        s2_nxt.as_wrap = sum;
        s2_nxt.as_ov   = sum < s1.b;
        s2_nxt.as_sat  = s2_nxt.as_ov ? s1.mask : sum;
      end
      osalu_pkg::FUNC_SSUB: begin
        s2_nxt.as_wrap = diff;
        s2_nxt.as_ov   = (s1.sa != s1.sb) && (diff_s != s1.sa);
        s2_nxt.as_sat  = s2_nxt.as_ov ? (s1.sa ? s1.smin : smax) : diff;
      end
      osalu_pkg::FUNC_USUB: begin
        s2_nxt.as_wrap = diff;
        s2_nxt.as_ov   = s1.b > s1.a;
        s2_nxt.as_sat  = s2_nxt.as_ov ? '0 : diff;
      end
      default: begin
        // multiplies finish later, unused codes stay zero
        s2_nxt.as_wrap = '0;
        s2_nxt.as_ov   = 1'b0;
        s2_nxt.as_sat  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_v = s2_v_r;
  assign s2   = s2_r;

endmodule

>>> rtl/osalu_mulsum.sv
// ----------------------------------------------------------------------------
// osalu_mulsum
// partial product sum into the low product word and a high-word flag
// ----------------------------------------------------------------------------
module osalu_mulsum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s2_v,
  input  osalu_pkg::s2_t   s2,
  output logic             s3_v,
  output osalu_pkg::s3_t   s3
);

  logic                          s3_v_r;
  osalu_pkg::s3_t                s3_r;
  osalu_pkg::s3_t                s3_nxt;
  logic [osalu_pkg::DATA_W-1:0]  mid;
  logic [osalu_pkg::DATA_W-1:0]  prod_hi;

  localparam int HW = osalu_pkg::HALF_W;
  localparam int DW = osalu_pkg::DATA_W;

  // middle column: carry out of the low half plus both cross terms
  assign mid = DW'(s2.pp_ll[DW-1:HW]) + DW'(s2.pp_lh[HW-1:0]) + DW'(s2.pp_hl[HW-1:0]);
  assign prod_hi = s2.pp_hh + DW'(s2.pp_lh[DW-1:HW]) + DW'(s2.pp_hl[DW-1:HW])
                 + DW'(mid[DW-1:HW]);

  always_comb begin
    s3_nxt.func       = s2.func;
    s3_nxt.mask       = s2.mask;
    s3_nxt.smin       = s2.smin;
    s3_nxt.neg        = s2.neg;
    s3_nxt.prod_lo    = {mid[HW-1:0], s2.pp_ll[HW-1:0]};
    s3_nxt.prod_hi_nz = |prod_hi;
    s3_nxt.as_wrap    = s2.as_wrap;
    s3_nxt.as_ov      = s2.as_ov;
    s3_nxt.as_sat     = s2.as_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
  end

  assign s3_v = s3_v_r;
  assign s3   = s3_r;

endmodule

>>> rtl/osalu_result.sv
// ----------------------------------------------------------------------------
// osalu_result
// multiply overflow and clamp, result select and output register
// ----------------------------------------------------------------------------
module osalu_result (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s3_v,
  input  osalu_pkg::s3_t   s3,
  output logic             res_v,
  output osalu_pkg::res_t  res
);

  logic                          res_v_r;
  osalu_pkg::res_t               res_r;
  osalu_pkg::res_t               res_nxt;
  logic [osalu_pkg::DATA_W-1:0]  smax;
  logic [osalu_pkg::DATA_W-1:0]  lim;
  logic [osalu_pkg::DATA_W-1:0]  smul_wrap;
  logic                          smul_ov;
  logic                          umul_ov;

  assign smax      = s3.mask >> 1;
  assign lim       = s3.neg ? s3.smin : smax;
  // magnitude product, negated back when the signs differ
  assign smul_wrap = (s3.neg ? (~s3.prod_lo + osalu_pkg::DATA_W'(1)) : s3.prod_lo)
                   & s3.mask;
  assign smul_ov   = s3.prod_hi_nz || (s3.prod_lo > lim);
  assign umul_ov   = s3.prod_hi_nz || (s3.prod_lo > s3.mask);

  always_comb begin
    case (s3.func)
      osalu_pkg::FUNC_SMUL: begin
        res_nxt.wrap = smul_wrap;
        res_nxt.ov   = smul_ov;
        res_nxt.sat  = smul_ov ? lim : smul_wrap;
      end
      osalu_pkg::FUNC_UMUL: begin
        res_nxt.wrap = s3.prod_lo & s3.mask;
        res_nxt.ov   = umul_ov;
        res_nxt.sat  = umul_ov ? s3.mask : (s3.prod_lo & s3.mask);
      end
      default: begin
        res_nxt.wrap = s3.as_wrap;
        res_nxt.ov   = s3.as_ov;
        res_nxt.sat  = s3.as_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_v = res_v_r;
  assign res   = res_r;

endmodule

>>> rtl/overflow_saturating_alu.sv
// ----------------------------------------------------------------------------
// overflow_saturating_alu
// saturating add, subtract and multiply, signed or unsigned, at a run-time
// width of 1 to 64 bits, giving wrapped result, overflow and clamped result
// ----------------------------------------------------------------------------
// path: a word taken at a clock edge passes the operand, add/partial product, product
//   sum and result registers behind the input register before it is on the out_ ports
//   with out_valid, where the receiver takes it
// throughput: one word every cycle, busy stays low, the receiver cannot stall
// the 64x64 multiply is split into four 32x32 partial products
// reset: synchronous active-low rst_n drops every word in flight, width back to 64
module overflow_saturating_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [osalu_pkg::FUNC_W-1:0]  in_func,
  input  logic [osalu_pkg::DATA_W-1:0]  in_lhs_value,
  input  logic [osalu_pkg::DATA_W-1:0]  in_rhs_value,
  // result channel
  output logic                          out_valid,
  output logic [osalu_pkg::DATA_W-1:0]  out_wrapped_result,
  output logic                          out_overflow,
  output logic [osalu_pkg::DATA_W-1:0]  out_saturated_result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [osalu_pkg::ADDR_W-1:0]  paddr,
  input  logic [osalu_pkg::APB_W-1:0]   pwdata,
  output logic [osalu_pkg::APB_W-1:0]   prdata,
  output logic                          pready
);

  osalu_pkg::cfg_t  cfg;
  osalu_pkg::op_t   op_r;
  osalu_pkg::op_t   op_nxt;
  logic             op_v_r;
  logic             accept;
  logic             s1_v, s2_v, s3_v, res_v;
  osalu_pkg::s1_t   s1;
  osalu_pkg::s2_t   s2;
  osalu_pkg::s3_t   s3;
  osalu_pkg::res_t  res;

  // fully pipelined, so a new word is always welcome
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  assign op_nxt.func = in_func;
  assign op_nxt.lhs  = in_lhs_value;
  assign op_nxt.rhs  = in_rhs_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r <= 1'b0;
    end else begin
      op_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

  // width register and its decode
  osalu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // mask operands, form multiply magnitudes
  osalu_operand u_operand (
    .clk   (clk),
    .rst_n (rst_n),
    .op_v  (op_v_r),
    .op    (op_r),
    .cfg   (cfg),
    .s1_v  (s1_v),
    .s1    (s1)
  );

  // add/sub finish here, multiply splits into partial products
  osalu_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_v  (s1_v),
    .s1    (s1),
    .s2_v  (s2_v),
    .s2    (s2)
  );

  // partial products summed into the low product word and a high-word flag
  osalu_mulsum u_mulsum (
    .clk   (clk),
    .rst_n (rst_n),
    .s2_v  (s2_v),
    .s2    (s2),
    .s3_v  (s3_v),
    .s3    (s3)
  );

  // multiply clamp and final select into the output register
  osalu_result u_result (
    .clk   (clk),
    .rst_n (rst_n),
    .s3_v  (s3_v),
    .s3    (s3),
    .res_v (res_v),
    .res   (res)
  );

  assign out_valid            = res_v;
  assign out_wrapped_result   = res.wrap;
  assign out_overflow         = res.ov;
  assign out_saturated_result = res.sat;

`ifndef SYNTHESIS
  // every accepted word, and nothing else, is taken by the receiver as a result strobe
  a_latency: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past(rst_n, 5)) |-> (out_valid == $past(start && !busy, 5)))
    else $error("result strobe does not match accepted word");

  // without overflow the clamp path must agree with the wrapped result
  a_no_ov_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |-> (out_saturated_result == out_wrapped_result))
    else $error("saturated result differs without overflow");

  // unused operation codes give an all-zero result
  a_unused_zero: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past(rst_n, 5)
     && $past(start && !busy && (in_func > osalu_pkg::FUNC_UMUL), 5))
    |-> (out_wrapped_result == '0 && !out_overflow && out_saturated_result == '0))
    else $error("unused operation code gave a nonzero result");
`endif

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for overflow_saturating_alu: a queued command driver
// with random idle bursts, a result monitor compared against a behavioral
// model of wrap, overflow and saturation, and width changes between phases
// ----------------------------------------------------------------------------
module testbench;

  // the two func codes with no operation behind them
  localparam logic [osalu_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [osalu_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  localparam int CLK_HIGH      = 6;
  localparam int CLK_LOW       = 6;
  localparam int PIPE_DRAIN    = 8;       // pipeline drain plus margin
  localparam int LIMIT_CYCLES  = 200000;
  localparam int WORDS_PER_SET = 34;
  localparam int PRINT_CAP     = 40;

  localparam logic [osalu_pkg::DATA_W-1:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [osalu_pkg::DATA_W-1:0] SMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [osalu_pkg::DATA_W-1:0] SMIN = 64'h8000_0000_0000_0000;

  logic                              clk;
  logic                              rst_n   = 1'b0;
  logic                              start   = 1'b0;
  logic                              busy;
  logic [osalu_pkg::FUNC_W-1:0]      in_func = '0;
  logic [osalu_pkg::DATA_W-1:0]      in_lhs_value = '0;
  logic [osalu_pkg::DATA_W-1:0]      in_rhs_value = '0;
  logic                              out_valid;
  logic [osalu_pkg::DATA_W-1:0]      out_wrapped_result;
  logic                              out_overflow;
  logic [osalu_pkg::DATA_W-1:0]      out_saturated_result;
  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [osalu_pkg::ADDR_W-1:0]      paddr   = '0;
  logic [osalu_pkg::APB_W-1:0]       pwdata  = '0;
  logic [osalu_pkg::APB_W-1:0]       prdata;
  logic                              pready;

  // bench state
  osalu_pkg::op_t                    pending_ops[$];    // words waiting for the driver
  osalu_pkg::res_t                   due_results[$];    // predicted results, oldest first
  logic [osalu_pkg::CFG_W-1:0]       width_shadow = 7'd64;
  logic                              word_taken = 1'b0; // driver's word went in at last edge
  logic                              calm = 1'b0;       // no idle bursts in the closing phase
  int unsigned                       idle_left = 0;
  int unsigned                       words_queued = 0;
  int unsigned                       words_taken = 0;
  int unsigned                       err_count = 0;

  overflow_saturating_alu dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_lhs_value         (in_lhs_value),
    .in_rhs_value         (in_rhs_value),
    .out_valid            (out_valid),
    .out_wrapped_result   (out_wrapped_result),
    .out_overflow         (out_overflow),
    .out_saturated_result (out_saturated_result),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    clk = 1'b1;
    #CLK_HIGH;
    clk = 1'b0;
    #CLK_LOW;
  end

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------

  // low-bit mask of the width in use; zero acts as one, above 64 acts as 64
  function automatic logic [osalu_pkg::DATA_W-1:0] width_mask(
      input logic [osalu_pkg::CFG_W-1:0] wreg);
    int unsigned ew;
    ew = (wreg == 0) ? 1 : (wreg > osalu_pkg::MAX_WIDTH) ? osalu_pkg::MAX_WIDTH
                                                           : int'(wreg);
    if (ew >= osalu_pkg::DATA_W)
      return ONES;
    return (64'd1 << ew) - 64'd1;
  endfunction

  // the exact result is formed in 130 bits, wide enough for any 64x64
  // product of either signedness, then checked against the width's range
  function automatic osalu_pkg::res_t alu_result(input osalu_pkg::op_t op,
                                                 input logic [osalu_pkg::CFG_W-1:0] wreg);
    logic [osalu_pkg::DATA_W-1:0] mask, smin, a, b;
    logic signed [129:0]          ax, bx, exact, hi_lim, lo_lim;
    logic                         is_signed, known_op;
    osalu_pkg::res_t              r;
    mask      = width_mask(wreg);
    smin      = (mask >> 1) + 64'd1;
    a         = op.lhs & mask;
    b         = op.rhs & mask;
    is_signed = (op.func == osalu_pkg::FUNC_SADD) || (op.func == osalu_pkg::FUNC_SSUB) ||
                (op.func == osalu_pkg::FUNC_SMUL);
    ax        = $signed({66'd0, a});
    bx        = $signed({66'd0, b});
    if (is_signed) begin
      // two's complement reading of the low width bits
      if ((a & smin) != 0)
        ax = ax - $signed({66'd0, mask}) - 130'sd1;
      if ((b & smin) != 0)
        bx = bx - $signed({66'd0, mask}) - 130'sd1;
      hi_lim = $signed({66'd0, smin - 64'd1});
      lo_lim = -$signed({66'd0, smin});
    end else begin
      hi_lim = $signed({66'd0, mask});
      lo_lim = '0;
    end
    known_op = 1'b1;
    case (op.func)
      osalu_pkg::FUNC_SADD, osalu_pkg::FUNC_UADD: exact = ax + bx;
      osalu_pkg::FUNC_SSUB, osalu_pkg::FUNC_USUB: exact = ax - bx;
      osalu_pkg::FUNC_SMUL, osalu_pkg::FUNC_UMUL: exact = ax * bx;
      default: begin
        exact    = '0;
        known_op = 1'b0;
      end
    endcase
    r.wrap = exact[osalu_pkg::DATA_W-1:0] & mask;
    r.ov   = known_op && ((exact > hi_lim) || (exact < lo_lim));
    if (!r.ov)
      r.sat = r.wrap;
    else if (exact < 0)
      r.sat = is_signed ? smin : '0;
    else
      r.sat = is_signed ? smin - 64'd1 : mask;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  // print is capped so a broken block cannot flood the log, count is not
  task automatic report_mismatch(input string what,
                                 input logic [osalu_pkg::DATA_W-1:0] got,
                                 input logic [osalu_pkg::DATA_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // monitor: compare every strobed result word, then log the word accepted
  // at this same edge; with the pipeline registers between them the order does not matter
  always @(posedge clk) begin : result_watch
    osalu_pkg::res_t want;
    osalu_pkg::op_t  seen;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with none due", out_wrapped_result, '0);
        end else begin
          want = due_results.pop_front();
          if (out_wrapped_result !== want.wrap)
            report_mismatch("wrapped_result", out_wrapped_result, want.wrap);
          if (out_overflow !== want.ov)
            report_mismatch("overflow", {63'd0, out_overflow}, {63'd0, want.ov});
          if (out_saturated_result !== want.sat)
            report_mismatch("saturated_result", out_saturated_result, want.sat);
        end
      end
      if (start && !busy) begin
        seen.func = in_func;
        seen.lhs  = in_lhs_value;
        seen.rhs  = in_rhs_value;
        due_results.push_back(alu_result(seen, width_shadow));
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  // holds a word until it is taken, then either idles for a burst or
  // presents the next queued word; idle cycles carry junk on the in_ ports
  always @(negedge clk) begin : word_driver
    osalu_pkg::op_t next_op;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (idle_left != 0) begin
        idle_left    <= idle_left - 1;
        start        <= 1'b0;
        in_func      <= osalu_pkg::FUNC_W'($urandom);
        in_lhs_value <= {$urandom, $urandom};
        in_rhs_value <= {$urandom, $urandom};
      end else if (pending_ops.size() != 0) begin
        next_op      = pending_ops.pop_front();
        start        <= 1'b1;
        in_func      <= next_op.func;
        in_lhs_value <= next_op.lhs;
        in_rhs_value <= next_op.rhs;
        if (!calm && $urandom_range(0, 11) == 0)
          idle_left <= $urandom_range(1, 15);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_word(input logic [osalu_pkg::FUNC_W-1:0] func,
                            input logic [osalu_pkg::DATA_W-1:0] lhs,
                            input logic [osalu_pkg::DATA_W-1:0] rhs);
    osalu_pkg::op_t op;
    op.func = func;
    op.lhs  = lhs;
    op.rhs  = rhs;
    pending_ops.push_back(op);
    words_queued++;
  endtask

  // random upper bits the block must ignore, low bits biased to the corners
  // of the current width: zero, one, all ones, minus two, signed min, max and min plus one
  function automatic logic [osalu_pkg::DATA_W-1:0] pick_operand();
    logic [osalu_pkg::DATA_W-1:0] mask, smin, raw, low;
    mask = width_mask(width_shadow);
    smin = (mask >> 1) + 64'd1;
    raw  = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       low = '0;
      1:       low = 64'd1;
      2:       low = mask;
      3:       low = mask - 64'd1;
      4:       low = smin;
      5:       low = smin - 64'd1;
      6:       low = smin + 64'd1;
      7:       low = {32'd0, $urandom} & (mask >> ($urandom_range(0, 3) * 8));
      default: low = {$urandom, $urandom};
    endcase
    return (raw & ~mask) | (low & mask);
  endfunction

  task automatic queue_random_set(input int count);
    logic [osalu_pkg::FUNC_W-1:0] func;
    repeat (count) begin
      if ($urandom_range(0, 19) < 18)
        func = osalu_pkg::FUNC_W'($urandom_range(osalu_pkg::FUNC_SADD,
                                                 osalu_pkg::FUNC_UMUL));
      else
        func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
      queue_word(func, pick_operand(), pick_operand());
    end
  endtask

  // every queued word taken and every due result seen, then let the
  // pipeline run empty before touching the width register
  task automatic wait_quiet();
    while (words_taken != words_queued || due_results.size() != 0)
      @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // two-phase apb write; upper data bits are noise the register drops
  task automatic write_width(input logic [osalu_pkg::CFG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {osalu_pkg::REG_WIDTH, 2'b00};
    pwdata  <= {25'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    width_shadow = value;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_sequence
    int width_plan [0:14];
    width_plan = '{1, 0, 2, 3, 8, 16, 31, 32, 33, 63, 127, 65,
                   $urandom_range(4, 62), $urandom_range(4, 62), 64};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset width of 64
    queue_word(osalu_pkg::FUNC_SADD, SMAX, 64'd1);    // positive wrap to min
    queue_word(osalu_pkg::FUNC_SADD, SMIN, ONES);     // min plus minus one
    queue_word(osalu_pkg::FUNC_SADD, 64'd0, 64'd0);
    queue_word(osalu_pkg::FUNC_UADD, ONES, 64'd1);    // carry out
    queue_word(osalu_pkg::FUNC_UADD, ONES, ONES);
    queue_word(osalu_pkg::FUNC_SSUB, SMIN, 64'd1);    // below min
    queue_word(osalu_pkg::FUNC_SSUB, SMAX, ONES);     // max minus minus one
    queue_word(osalu_pkg::FUNC_SSUB, 64'd0, SMIN);    // zero minus min
    queue_word(osalu_pkg::FUNC_USUB, 64'd0, 64'd1);   // borrow clamps to zero
    queue_word(osalu_pkg::FUNC_USUB, ONES, ONES);
    queue_word(osalu_pkg::FUNC_SMUL, SMIN, ONES);     // min times minus one
    queue_word(osalu_pkg::FUNC_SMUL, SMIN, 64'd1);    // fits exactly
    queue_word(osalu_pkg::FUNC_SMUL, ONES, ONES);
    queue_word(osalu_pkg::FUNC_SMUL, SMAX, 64'd2);
    queue_word(osalu_pkg::FUNC_SMUL, 64'h0000_0001_0000_0000, 64'hffff_ffff_8000_0000);
    queue_word(osalu_pkg::FUNC_SMUL, SMIN, 64'd0);
    queue_word(osalu_pkg::FUNC_UMUL, ONES, ONES);
    queue_word(osalu_pkg::FUNC_UMUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
    queue_word(osalu_pkg::FUNC_UMUL, 64'h0000_0000_ffff_ffff, 64'h0000_0000_ffff_ffff);
    queue_word(FUNC_SPARE_A, ONES, ONES);              // no operation, all zero
    queue_word(FUNC_SPARE_B, SMAX, 64'd5);
    queue_random_set(WORDS_PER_SET);

    // one random set per width, including zero and values above 64;
    // the last set runs without idle bursts
    foreach (width_plan[i]) begin
      wait_quiet();
      write_width(osalu_pkg::CFG_W'(width_plan[i]));
      if (i == $high(width_plan))
        calm = 1'b1;
      queue_random_set(WORDS_PER_SET);
    end

    wait_quiet();
    if (err_count == 0)
      $display("[overflow_saturating_alu] OK");
    else
      $display("[overflow_saturating_alu] ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : hang_guard
    #(LIMIT_CYCLES * (CLK_HIGH + CLK_LOW));
    $display("[overflow_saturating_alu] ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/osalu_pkg.sv
rtl/osalu_cfg.sv
rtl/osalu_operand.sv
rtl/osalu_core.sv
rtl/osalu_mulsum.sv
rtl/osalu_result.sv
rtl/overflow_saturating_alu.sv
sim/testbench.sv
